>>> sv/lca_pkg.sv
// ----------------------------------------------------------------------------
// Lowest common ancestor package
// Shared constants, request and status codes for the ancestor query block.
// ----------------------------------------------------------------------------
package lca_pkg;

   localparam int MaxNodes  = 16384;
   localparam int LogLevels = 14;
   localparam int IdWidth   = 14;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_EDGE  = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_NO_ROOT = 2'd2
   } status_code_type;

endpackage

>>> sv/lca_jump_mem.sv
// ----------------------------------------------------------------------------
// Jump table memory
// One synchronous memory holding, per level and node, the 2^k-th ancestor.
// ----------------------------------------------------------------------------
module lca_jump_mem #(
   parameter int AW = 18,
   parameter int DW = 14
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> sv/lowest_common_ancestor.sv
// ----------------------------------------------------------------------------
// Lowest common ancestor
// Keeps a parent table and answers ancestor queries with binary lifting.
//
//   channel  direction  handshake
//   req_     in         start / busy
//   rsp_     out        strobe, one cycle
//   csr_     in         csr_valid / csr_ready
//
// A request is taken when start is high and busy is low; clear keeps busy high
// while it rewrites every parent entry, edge while it writes one.
// The first query after any change rebuilds the tables first, level by level
// through the one jump memory port, then the depths. A query then holds busy
// while it compares depths and walks the jump table, and its result is strobed
// in the first idle cycle; a query with a bad id is answered in the cycle after
// it is taken, without busy.
// After reset a clearing pass over all MAX_NODES entries runs with busy high.
// The receiver cannot stall; results are shown for one cycle.
// ----------------------------------------------------------------------------
module lowest_common_ancestor #(
   parameter int MAX_NODES  = lca_pkg::MaxNodes,
   parameter int LOG_LEVELS = lca_pkg::LogLevels
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [13:0] req_node_a,
   input  logic [13:0] req_node_b,
   output logic        strobe,
   output logic [13:0] rsp_ancestor,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [13:0] csr_node_count
);
   localparam int IW = lca_pkg::IdWidth;
   localparam int NW = $clog2(MAX_NODES);
   localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
   localparam int AW = NW + LW;
   localparam int SW = LOG_LEVELS + 1;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_CLR, S_EDGE,
      S_B0R, S_B0W,
      S_BKR1, S_BKR2, S_BKW,
      S_DR, S_DW, S_DF, S_DW2,
      S_QA, S_QB, S_QC,
      S_L1R, S_L1W,
      S_L2S, S_L2A, S_L2B, S_L2C,
      S_FR, S_FW, S_OUT
   } state_type;

   state_type     state_ff;
   logic [IW-1:0] cnt_ff;
   logic          stale_ff;
   logic [NW-1:0] v_ff;
   logic [LW-1:0] k_ff;
   logic [IW-1:0] a_ff, b_ff, pa_ff;
   logic [IW-1:0] cur_ff;
   logic [SW-1:0] steps_ff;
   logic [IW-1:0] da_ff;
   logic [IW-1:0] diff_ff;
   logic [IW-1:0] res_ff;
   logic [1:0]    st_ff;
   logic          strobe_ff;

   logic [IW-1:0] par_mem [MAX_NODES];
   logic [IW-1:0] dep_mem [MAX_NODES];
   logic          par_we, dep_we;
   logic [NW-1:0] par_wa, par_ra, dep_wa, dep_ra;
   logic [IW-1:0] par_wd, dep_wd, par_rd, dep_rd;

   logic          j_we;
   logic [AW-1:0] j_wa, j_ra;
   logic [IW-1:0] j_wd, j_rd;

   lca_jump_mem #(.AW(AW), .DW(IW)) u_jump (
      .clock(clock), .wr_en(j_we), .wr_addr(j_wa), .wr_data(j_wd),
      .rd_addr(j_ra), .rd_data(j_rd)
   );

   always_ff @(posedge clock) begin
      if (par_we) par_mem[par_wa] <= par_wd;
      par_rd <= par_mem[par_ra];
      if (dep_we) dep_mem[dep_wa] <= dep_wd;
      dep_rd <= dep_mem[dep_ra];
   end

   logic [IW-1:0] used;
   assign used = (32'(cnt_ff) > MAX_NODES - 1) ? IW'(MAX_NODES - 1) : cnt_ff;

   function automatic logic [AW-1:0] jaddr(input logic [LW-1:0] k,
                                           input logic [IW-1:0] n);
      return {k, NW'(n)};
   endfunction

   logic a_bad, b_bad;
   assign a_bad = (req_node_a == '0) || (req_node_a > used);
   assign b_bad = (req_node_b == '0) || (req_node_b > used);

   // Combinational memory controls by state.
   always_comb begin
      par_we = 1'b0;
      par_wa = v_ff;
      par_wd = '0;
      par_ra = v_ff;
      dep_we = 1'b0;
      dep_wa = v_ff;
      dep_wd = '0;
      dep_ra = NW'(a_ff);
      j_we = 1'b0;
      j_wa = jaddr(k_ff, IW'(v_ff));
      j_wd = '0;
      j_ra = jaddr(k_ff, cur_ff);
      case (state_ff)
         S_INIT, S_CLR: begin
            par_we = 1'b1;
         end
         S_EDGE: begin
            par_we = 1'b1;
            par_wa = NW'(b_ff);
            par_wd = a_ff;
         end
         S_B0W: begin
            j_we = 1'b1;
            j_wa = jaddr('0, IW'(v_ff));
            j_wd = (v_ff == '0 || par_rd > used) ? '0 : par_rd;
         end
         S_BKR1: j_ra = jaddr(k_ff - LW'(1), IW'(v_ff));
         S_BKR2: j_ra = jaddr(k_ff - LW'(1), j_rd);
         S_BKW: begin
            j_we = 1'b1;
            j_wd = j_rd;
         end
         S_DR: j_ra = jaddr(k_ff, cur_ff);
         S_DF: j_ra = jaddr('0, cur_ff);
         S_DW2: begin
            dep_we = 1'b1;
            dep_wd = (v_ff == '0 || j_rd != '0) ? '0 : IW'(steps_ff + SW'(1));
         end
         S_QB: dep_ra = NW'(b_ff);
         S_L1R: j_ra = jaddr(k_ff, a_ff);
         S_L2A: j_ra = jaddr(k_ff, a_ff);
         S_L2B: j_ra = jaddr(k_ff, b_ff);
         S_FR: j_ra = jaddr('0, a_ff);
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign strobe = strobe_ff;
   assign rsp_ancestor = res_ff;
   assign rsp_status = st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff <= IW'(1);
         stale_ff <= 1'b1;
         v_ff <= '0;
         k_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_INIT, S_CLR: begin
               v_ff <= v_ff + NW'(1);
               if (v_ff == NW'(MAX_NODES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (csr_valid && csr_ready) begin
                  cnt_ff <= csr_node_count;
                  stale_ff <= 1'b1;
               end
               if (start) begin
                  a_ff <= req_node_a;
                  b_ff <= req_node_b;
                  v_ff <= '0;
                  k_ff <= '0;
                  case (req_type)
                     lca_pkg::REQ_CLEAR: begin
                        stale_ff <= 1'b1;
                        state_ff <= S_CLR;
                     end
                     lca_pkg::REQ_EDGE: begin
                        if (!a_bad && !b_bad) begin
                           stale_ff <= 1'b1;
                           state_ff <= S_EDGE;
                        end
                     end
                     lca_pkg::REQ_QUERY: begin
                        if (a_bad || b_bad) begin
                           res_ff <= '0;
                           st_ff <= lca_pkg::ST_RANGE;
                           strobe_ff <= 1'b1;
                        end else if (stale_ff) begin
                           state_ff <= S_B0R;
                        end else begin
                           state_ff <= S_QA;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_EDGE: state_ff <= S_IDLE;
            S_B0R: state_ff <= S_B0W;
            S_B0W: begin
               if (IW'(v_ff) == used) begin
                  v_ff <= '0;
                  if (LOG_LEVELS > 1) begin
                     k_ff <= LW'(1);
                     state_ff <= S_BKR1;
                  end else begin
                     k_ff <= LW'(LOG_LEVELS - 1);
                     cur_ff <= '0;
                     steps_ff <= '0;
                     state_ff <= S_DR;
                  end
               end else begin
                  v_ff <= v_ff + NW'(1);
                  state_ff <= S_B0R;
               end
            end
            S_BKR1: state_ff <= S_BKR2;
            S_BKR2: state_ff <= S_BKW;
            S_BKW: begin
               if (IW'(v_ff) == used) begin
                  v_ff <= '0;
                  if (k_ff == LW'(LOG_LEVELS - 1)) begin
                     cur_ff <= '0;
                     steps_ff <= '0;
                     state_ff <= S_DR;
                  end else begin
                     k_ff <= k_ff + LW'(1);
                     state_ff <= S_BKR1;
                  end
               end else begin
                  v_ff <= v_ff + NW'(1);
                  state_ff <= S_BKR1;
               end
            end
            S_DR: state_ff <= S_DW;
            S_DW: begin
               if (j_rd != '0) begin
                  cur_ff <= j_rd;
                  steps_ff <= steps_ff + (SW'(1) << k_ff);
               end
               if (k_ff == '0) begin
                  state_ff <= S_DF;
               end else begin
                  k_ff <= k_ff - LW'(1);
                  state_ff <= S_DR;
               end
            end
            S_DF: state_ff <= S_DW2;
            S_DW2: begin
               k_ff <= LW'(LOG_LEVELS - 1);
               steps_ff <= '0;
               if (IW'(v_ff) == used) begin
                  stale_ff <= 1'b0;
                  state_ff <= S_QA;
               end else begin
                  v_ff <= v_ff + NW'(1);
                  cur_ff <= IW'(v_ff + NW'(1));
                  state_ff <= S_DR;
               end
            end
            S_QA: state_ff <= S_QB;
            S_QB: begin
               da_ff <= dep_rd;
               state_ff <= S_QC;
            end
            S_QC: begin
               k_ff <= '0;
               if (da_ff == '0 || dep_rd == '0) begin
                  res_ff <= '0;
                  st_ff <= lca_pkg::ST_NO_ROOT;
                  strobe_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (da_ff < dep_rd) begin
                  a_ff <= b_ff;
                  b_ff <= a_ff;
                  diff_ff <= dep_rd - da_ff;
                  state_ff <= S_L1R;
               end else begin
                  diff_ff <= da_ff - dep_rd;
                  state_ff <= S_L1R;
               end
            end
            S_L1R: begin
               if (diff_ff[k_ff]) begin
                  state_ff <= S_L1W;
               end else if (k_ff == LW'(LOG_LEVELS - 1)) begin
                  state_ff <= S_L2S;
               end else begin
                  k_ff <= k_ff + LW'(1);
               end
            end
            S_L1W: begin
               a_ff <= j_rd;
               if (k_ff == LW'(LOG_LEVELS - 1)) begin
                  state_ff <= S_L2S;
               end else begin
                  k_ff <= k_ff + LW'(1);
                  state_ff <= S_L1R;
               end
            end
            S_L2S: begin
               if (a_ff == b_ff) begin
                  state_ff <= S_OUT;
               end else begin
                  k_ff <= LW'(LOG_LEVELS - 1);
                  state_ff <= S_L2A;
               end
            end
            S_L2A: state_ff <= S_L2B;
            S_L2B: begin
               pa_ff <= j_rd;
               state_ff <= S_L2C;
            end
            S_L2C: begin
               if (pa_ff != j_rd) begin
                  a_ff <= pa_ff;
                  b_ff <= j_rd;
               end
               if (k_ff == '0) begin
                  state_ff <= S_FR;
               end else begin
                  k_ff <= k_ff - LW'(1);
                  state_ff <= S_L2A;
               end
            end
            S_FR: state_ff <= S_FW;
            S_FW: begin
               a_ff <= j_rd;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               strobe_ff <= 1'b1;
               if (a_ff == '0) begin
                  res_ff <= '0;
                  st_ff <= lca_pkg::ST_NO_ROOT;
               end else begin
                  res_ff <= a_ff;
                  st_ff <= lca_pkg::ST_OK;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> state_ff == S_IDLE)
      else $error("result shown while not idle");
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && st_ff != lca_pkg::ST_OK) |-> res_ff == '0)
      else $error("ancestor not zero on failed query");
   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !busy)
      else $error("register write while busy");
endmodule

>>> sim/lca_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lowest common ancestor checker
// Watches the request, response and register channels of the ancestor block,
// keeps its own copy of the parent table, predicts every query answer by
// walking parent chains and compares each response with the oldest answer.
// ----------------------------------------------------------------------------
module lca_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_type,
   input  logic [13:0] req_node_a,
   input  logic [13:0] req_node_b,
   input  logic        strobe,
   input  logic [13:0] rsp_ancestor,
   input  logic [1:0]  rsp_status,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [13:0] csr_node_count,
   output int          fail_count,
   output int          pending,
   output int          answered
);

   typedef struct packed {
      logic [13:0]                 ancestor;
      lca_pkg::status_code_type    status;
   } answer_type;

   logic [13:0] parent_of [0:lca_pkg::MaxNodes-1];
   logic [13:0] nodes_in_use;
   answer_type  answer_queue [$];

   assign pending = answer_queue.size();

   function automatic logic [13:0] link_of(input logic [13:0] v);
      logic [13:0] p;
      p = parent_of[v];
      return (p > nodes_in_use) ? 14'd0 : p;
   endfunction

   // Depth of a node, one for a root, zero when its chain never reaches a root.
   function automatic int depth_of(input logic [13:0] v);
      logic [13:0] cur;
      int          steps;
      cur = v;
      steps = 0;
      while (link_of(cur) != 0 && steps < (1 << lca_pkg::LogLevels) - 1) begin
         cur = link_of(cur);
         steps++;
      end
      return (link_of(cur) == 0) ? steps + 1 : 0;
   endfunction

   function automatic answer_type predict_ancestor(input logic [13:0] a,
                                                    input logic [13:0] b);
      answer_type  ans;
      int          da;
      int          db;
      logic [13:0] x;
      logic [13:0] y;
      ans = '{ancestor: 14'd0, status: lca_pkg::ST_OK};
      if (a == 0 || a > nodes_in_use || b == 0 || b > nodes_in_use) begin
         ans.status = lca_pkg::ST_RANGE;
         return ans;
      end
      da = depth_of(a);
      db = depth_of(b);
      if (da == 0 || db == 0) begin
         ans.status = lca_pkg::ST_NO_ROOT;
         return ans;
      end
      x = a;
      y = b;
      while (da > db) begin
         x = link_of(x);
         da--;
      end
      while (db > da) begin
         y = link_of(y);
         db--;
      end
      while (x != y) begin
         x = link_of(x);
         y = link_of(y);
      end
      if (x == 0) ans.status = lca_pkg::ST_NO_ROOT;
      else ans.ancestor = x;
      return ans;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         foreach (parent_of[i]) parent_of[i] = 14'd0;
         nodes_in_use = 14'd1;
         answer_queue.delete();
      end else begin
         if (strobe) begin
            if (answer_queue.size() == 0) begin
               report_mismatch("unexpected response");
            end else begin
               want = answer_queue.pop_front();
               answered++;
               if (rsp_ancestor !== want.ancestor)
                  report_mismatch($sformatf("ancestor %0d, expected %0d",
                                            rsp_ancestor, want.ancestor));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
            end
         end
         if (csr_valid && csr_ready) nodes_in_use = csr_node_count;
         if (start && !busy) begin
            case (req_type)
               lca_pkg::REQ_CLEAR: begin
                  foreach (parent_of[i]) parent_of[i] = 14'd0;
               end
               lca_pkg::REQ_EDGE: begin
                  if (req_node_a != 0 && req_node_a <= nodes_in_use &&
                      req_node_b != 0 && req_node_b <= nodes_in_use)
                     parent_of[req_node_b] = req_node_a;
               end
               lca_pkg::REQ_QUERY: begin
                  answer_queue.insert(answer_queue.size(),
                                      predict_ancestor(req_node_a, req_node_b));
               end
               default: ;
            endcase
         end
      end
   end

endmodule

>>> sim/tb_lowest_common_ancestor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lowest common ancestor testbench
// Builds random trees and forests of varied sizes, mixes in cycles, stray and
// out-of-range requests, resizes the node count between phases and lets the
// checker compare every query answer against its own prediction.
// ----------------------------------------------------------------------------
module tb_lowest_common_ancestor;

   localparam int WatchdogLimit = 6000000;
   localparam int ItemTarget    = 750;
   localparam int QuietTail     = 650;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_type;
   logic [13:0] req_node_a;
   logic [13:0] req_node_b;
   logic        strobe;
   logic [13:0] rsp_ancestor;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [13:0] csr_node_count;
   int          fail_count;
   int          pending;
   int          answered;
   int          item_count;
   int          phase_count;
   int          idle_cycles;
   int          node_total;

   lowest_common_ancestor u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .strobe         (strobe),
      .rsp_ancestor   (rsp_ancestor),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_node_count (csr_node_count)
   );

   lca_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .strobe         (strobe),
      .rsp_ancestor   (rsp_ancestor),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_node_count (csr_node_count),
      .fail_count     (fail_count),
      .pending        (pending),
      .answered       (answered)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("lowest_common_ancestor: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic random_gap();
      if (item_count < QuietTail && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic send_request(input lca_pkg::req_code_type code,
                               input logic [13:0] a, input logic [13:0] b);
      random_gap();
      start      <= 1'b1;
      req_type   <= code;
      req_node_a <= a;
      req_node_b <= b;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (code != lca_pkg::REQ_NONE) item_count++;
   endtask

   task automatic write_node_count(input logic [13:0] value);
      start <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
      repeat (node_total + 8) @(negedge clock);
      if (item_count < QuietTail && $urandom_range(0, 1) == 0)
         repeat ($urandom_range(1, 12)) @(negedge clock);
      csr_valid      <= 1'b1;
      csr_node_count <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid  <= 1'b0;
      node_total = value;
      phase_count++;
   endtask

   function automatic logic [13:0] any_node();
      return (node_total == 0) ? 14'd0 : 14'($urandom_range(1, node_total));
   endfunction

   task automatic grow_forest();
      bit deep_chain;
      deep_chain = ($urandom_range(0, 3) == 0);
      for (int v = 2; v <= node_total; v++) begin
         if ($urandom_range(0, 9) != 0)
            send_request(lca_pkg::REQ_EDGE,
                         deep_chain ? 14'(v - 1) : 14'($urandom_range(1, v - 1)),
                         14'(v));
      end
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_request(lca_pkg::REQ_NONE, 14'($urandom), 14'($urandom));
         1: send_request(lca_pkg::REQ_EDGE, 14'($urandom), 14'($urandom));
         2: send_request(lca_pkg::REQ_EDGE, any_node(), any_node());
         default: send_request(lca_pkg::REQ_QUERY, 14'($urandom), 14'($urandom));
      endcase
   endtask

   initial begin
      int size;
      start          = 1'b0;
      req_type       = lca_pkg::REQ_NONE;
      req_node_a     = '0;
      req_node_b     = '0;
      csr_valid      = 1'b0;
      csr_node_count = 14'd1;
      item_count     = 0;
      phase_count    = 0;
      node_total     = 1;
      reset          = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(lca_pkg::REQ_QUERY, 14'd1, 14'd1);
      send_request(lca_pkg::REQ_QUERY, 14'd0, 14'd1);
      send_request(lca_pkg::REQ_QUERY, 14'd1, 14'd2);
      send_request(lca_pkg::REQ_EDGE, 14'd1, 14'd1);
      send_request(lca_pkg::REQ_QUERY, 14'd1, 14'd1);
      send_request(lca_pkg::REQ_CLEAR, 14'd0, 14'd0);

      write_node_count(14'd16383);
      send_request(lca_pkg::REQ_EDGE, 14'd16382, 14'd16383);
      send_request(lca_pkg::REQ_EDGE, 14'd1, 14'd16382);
      send_request(lca_pkg::REQ_EDGE, 14'd0, 14'd5);
      send_request(lca_pkg::REQ_NONE, 14'h3FFF, 14'h3FFF);
      send_request(lca_pkg::REQ_QUERY, 14'd16383, 14'd16382);
      send_request(lca_pkg::REQ_QUERY, 14'd16383, 14'd1);
      send_request(lca_pkg::REQ_QUERY, 14'd8191, 14'd8192);
      send_request(lca_pkg::REQ_QUERY, 14'd16383, 14'd0);
      send_request(lca_pkg::REQ_QUERY, 14'h2AAA, 14'h1555);
      send_request(lca_pkg::REQ_CLEAR, 14'd0, 14'd0);

      write_node_count(14'd0);
      send_request(lca_pkg::REQ_EDGE, 14'd1, 14'd1);
      send_request(lca_pkg::REQ_QUERY, 14'd1, 14'd1);

      while (item_count < ItemTarget) begin
         case ($urandom_range(0, 9))
            0: size = 1;
            1: size = $urandom_range(100, 200);
            default: size = $urandom_range(2, 40);
         endcase
         write_node_count(14'(size));
         send_request(lca_pkg::REQ_CLEAR, 14'($urandom), 14'($urandom));
         grow_forest();
         repeat ($urandom_range(10, 25))
            send_request(lca_pkg::REQ_QUERY, any_node(), any_node());
         repeat ($urandom_range(0, 5)) send_noise();
         repeat ($urandom_range(2, 6))
            send_request(lca_pkg::REQ_QUERY, any_node(), any_node());
         if ($urandom_range(0, 2) == 0) begin
            write_node_count(14'((size + 1) / 2));
            repeat ($urandom_range(4, 10))
               send_request(lca_pkg::REQ_QUERY, any_node(), any_node());
         end
      end

      start <= 1'b0;
      wait (pending == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d requests over %0d node-count settings; %0d queries answered.",
               item_count, phase_count, answered);
      if (fail_count == 0) begin
         $display("lowest_common_ancestor: match");
      end else begin
         $display("lowest_common_ancestor: mismatch");
      end
      $finish;
   end

endmodule
